// ===== src/si_pkg.sv =====
// ----------------------------------------------------------------------------
// si_pkg
// Shared types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package si_pkg;

    // Control that travels beside the data from the range-test stage onward.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;   // x offset is subtracted from the base
        logic neg_y;   // y offset is subtracted from the base
    } ctrl_t;

endpackage

// ===== src/si_in_if.sv =====
// ----------------------------------------------------------------------------
// si_in_if
// Input channel: one segment pair per transfer.
// ----------------------------------------------------------------------------
interface si_in_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

// ===== src/si_out_if.sv =====
// ----------------------------------------------------------------------------
// si_out_if
// Result channel: hit flag and fixed-point meeting point.
// ----------------------------------------------------------------------------
interface si_out_if #(parameter int OUT_BITS = 24);
    logic valid;
    logic ready;
    logic hit;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input  valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== src/si_setup.sv =====
// ----------------------------------------------------------------------------
// si_setup
// Front stages: differences, cross products, range test, magnitudes and the
// scaled dividends that feed the divider cell row.
// ----------------------------------------------------------------------------
module si_setup
    import si_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] a_start_x,
    input  logic signed [COORD_BITS-1:0] a_start_y,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_y,
    input  logic signed [COORD_BITS-1:0] b_start_x,
    input  logic signed [COORD_BITS-1:0] b_start_y,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_y,
    output ctrl_t                        ctrl,
    output logic [2*COORD_BITS+1:0]      rem_x,
    output logic [2*COORD_BITS+1:0]      rem_y,
    output logic [COORD_BITS+FRAC_BITS-1:0] low_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] low_y,
    output logic [2*COORD_BITS+1:0]      dvs,
    output logic signed [COORD_BITS-1:0] base_x,
    output logic signed [COORD_BITS-1:0] base_y
);
    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;            // coordinate differences
    localparam int SW = 2*COORD_BITS + 2;          // cross products
    localparam int Q  = COORD_BITS + FRAC_BITS;    // quotient bits
    localparam int NW = COORD_BITS + SW + FRAC_BITS;

    // stage 1: differences
    logic signed [DW-1:0] sax_reg, say_reg, sbx_reg, sby_reg, ex_reg, ey_reg;
    logic signed [C-1:0]  bx1_reg, by1_reg;
    logic                 v1_reg;

    // stage 2: products
    logic signed [SW-1:0] pd0_reg, pd1_reg, ps0_reg, ps1_reg, pt0_reg, pt1_reg;
    logic signed [DW-1:0] sax2_reg, say2_reg;
    logic signed [C-1:0]  bx2_reg, by2_reg;
    logic                 v2_reg;

    // stage 3: den, sn, tn
    logic signed [SW-1:0] den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0] sax3_reg, say3_reg;
    logic signed [C-1:0]  bx3_reg, by3_reg;
    logic                 v3_reg;

    // stage 4: range test and magnitudes
    ctrl_t                c4_reg;
    logic [SW-1:0]        dmag_reg, tmag_reg;
    logic [C-1:0]         xmag_reg, ymag_reg;
    logic signed [C-1:0]  bx4_reg, by4_reg;

    // stage 5: scaled dividends
    ctrl_t                c5_reg;
    logic [NW-1:0]        nx_reg, ny_reg;
    logic [SW-1:0]        d5_reg;
    logic signed [C-1:0]  bx5_reg, by5_reg;

    logic                 den_pos;
    logic                 s_ok;
    logic                 t_ok;
    logic [NW-1:0]        nx_next;
    logic [NW-1:0]        ny_next;

    always_comb
    begin
        den_pos = (den_reg > 0);
        s_ok = den_pos ? (sn_reg >= 0 && sn_reg <= den_reg)
                       : (sn_reg <= 0 && sn_reg >= den_reg);
        t_ok = den_pos ? (tn_reg >= 0 && tn_reg <= den_reg)
                       : (tn_reg <= 0 && tn_reg >= den_reg);
        nx_next = (NW'(xmag_reg) * NW'(tmag_reg)) << FRAC_BITS;
        ny_next = (NW'(ymag_reg) * NW'(tmag_reg)) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            c4_reg.valid <= v3_reg;
            c4_reg.hit   <= (den_reg != 0) && s_ok && t_ok;
            c4_reg.neg_x <= sax3_reg[DW-1];
            c4_reg.neg_y <= say3_reg[DW-1];
            c5_reg <= c4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sax_reg <= DW'(a_end_x) - DW'(a_start_x);
            say_reg <= DW'(a_end_y) - DW'(a_start_y);
            sbx_reg <= DW'(b_end_x) - DW'(b_start_x);
            sby_reg <= DW'(b_end_y) - DW'(b_start_y);
            ex_reg  <= DW'(a_start_x) - DW'(b_start_x);
            ey_reg  <= DW'(a_start_y) - DW'(b_start_y);
            bx1_reg <= a_start_x;
            by1_reg <= a_start_y;

            pd0_reg  <= SW'(sax_reg) * SW'(sby_reg);
            pd1_reg  <= SW'(sbx_reg) * SW'(say_reg);
            ps0_reg  <= SW'(sax_reg) * SW'(ey_reg);
            ps1_reg  <= SW'(say_reg) * SW'(ex_reg);
            pt0_reg  <= SW'(sbx_reg) * SW'(ey_reg);
            pt1_reg  <= SW'(sby_reg) * SW'(ex_reg);
            sax2_reg <= sax_reg;
            say2_reg <= say_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;

            den_reg  <= pd0_reg - pd1_reg;
            sn_reg   <= ps0_reg - ps1_reg;
            tn_reg   <= pt0_reg - pt1_reg;
            sax3_reg <= sax2_reg;
            say3_reg <= say2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;

            dmag_reg <= den_reg[SW-1] ? SW'(-den_reg) : SW'(den_reg);
            tmag_reg <= tn_reg[SW-1]  ? SW'(-tn_reg)  : SW'(tn_reg);
            xmag_reg <= sax3_reg[DW-1] ? C'(-sax3_reg) : C'(sax3_reg);
            ymag_reg <= say3_reg[DW-1] ? C'(-say3_reg) : C'(say3_reg);
            bx4_reg  <= bx3_reg;
            by4_reg  <= by3_reg;

            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            d5_reg  <= dmag_reg;
            bx5_reg <= bx4_reg;
            by5_reg <= by4_reg;
        end
    end

    // The quotient fits Q bits, so the dividend bits above Q start out as
    // the partial remainder, already below the divisor.
    assign ctrl   = c5_reg;
    assign rem_x  = nx_reg[NW-1:Q];
    assign rem_y  = ny_reg[NW-1:Q];
    assign low_x  = nx_reg[Q-1:0];
    assign low_y  = ny_reg[Q-1:0];
    assign dvs    = d5_reg;
    assign base_x = bx5_reg;
    assign base_y = by5_reg;

endmodule

// ===== src/si_div_cell.sv =====
// ----------------------------------------------------------------------------
// si_div_cell
// One restoring-division step for x and y; hands its state to the next cell.
// ----------------------------------------------------------------------------
module si_div_cell
    import si_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  ctrl_t                              ctrl_in,
    input  logic [2*COORD_BITS+1:0]            rem_x_in,
    input  logic [2*COORD_BITS+1:0]            rem_y_in,
    input  logic [COORD_BITS+FRAC_BITS-1:0]    low_x_in,
    input  logic [COORD_BITS+FRAC_BITS-1:0]    low_y_in,
    input  logic [COORD_BITS+FRAC_BITS-1:0]    q_x_in,
    input  logic [COORD_BITS+FRAC_BITS-1:0]    q_y_in,
    input  logic [2*COORD_BITS+1:0]            dvs_in,
    input  logic signed [COORD_BITS-1:0]       base_x_in,
    input  logic signed [COORD_BITS-1:0]       base_y_in,
    output ctrl_t                              ctrl_out,
    output logic [2*COORD_BITS+1:0]            rem_x_out,
    output logic [2*COORD_BITS+1:0]            rem_y_out,
    output logic [COORD_BITS+FRAC_BITS-1:0]    low_x_out,
    output logic [COORD_BITS+FRAC_BITS-1:0]    low_y_out,
    output logic [COORD_BITS+FRAC_BITS-1:0]    q_x_out,
    output logic [COORD_BITS+FRAC_BITS-1:0]    q_y_out,
    output logic [2*COORD_BITS+1:0]            dvs_out,
    output logic signed [COORD_BITS-1:0]       base_x_out,
    output logic signed [COORD_BITS-1:0]       base_y_out
);
    localparam int M = 2*COORD_BITS + 2;
    localparam int Q = COORD_BITS + FRAC_BITS;

    ctrl_t               ctrl_reg;
    logic [M-1:0]        rx_reg, ry_reg, d_reg;
    logic [Q-1:0]        lx_reg, ly_reg, qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] bx_reg, by_reg;

    logic [M:0]          tx, ty;
    logic                gx, gy;

    always_comb
    begin
        tx = {rem_x_in, low_x_in[Q-1]};
        ty = {rem_y_in, low_y_in[Q-1]};
        gx = (tx >= {1'b0, dvs_in});
        gy = (ty >= {1'b0, dvs_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= gx ? M'(tx - {1'b0, dvs_in}) : M'(tx);
            ry_reg <= gy ? M'(ty - {1'b0, dvs_in}) : M'(ty);
            lx_reg <= low_x_in << 1;
            ly_reg <= low_y_in << 1;
            qx_reg <= {q_x_in[Q-2:0], gx};
            qy_reg <= {q_y_in[Q-2:0], gy};
            d_reg  <= dvs_in;
            bx_reg <= base_x_in;
            by_reg <= base_y_in;
        end
    end

    assign ctrl_out   = ctrl_reg;
    assign rem_x_out  = rx_reg;
    assign rem_y_out  = ry_reg;
    assign low_x_out  = lx_reg;
    assign low_y_out  = ly_reg;
    assign q_x_out    = qx_reg;
    assign q_y_out    = qy_reg;
    assign dvs_out    = d_reg;
    assign base_x_out = bx_reg;
    assign base_y_out = by_reg;

endmodule

// ===== src/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_intersection
// Segment pair intersection test with a fixed-point meeting point.
// ----------------------------------------------------------------------------
// Accepts one segment pair per clock while results are taken and returns
// one result per pair, in order. There are COORD_BITS + FRAC_BITS + 6
// register stages: five setup stages (differences, cross products,
// den/sn/tn, range test, scaled dividend), one divider cell per quotient
// bit, and the output register. The whole pipeline advances together; it
// holds only while a result sits in the output register and the sink is
// not ready, so the input keeps flowing as long as results are taken.
// Parallel, collinear or degenerate segments give hit = 0. With no hit the
// point is zero. On a hit the point is a_start + t*(a_end - a_start), with
// the offset truncated toward zero, FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module segment_intersection
    import si_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    si_in_if.sink    seg_pair,
    si_out_if.source result
);
    localparam int C   = COORD_BITS;
    localparam int M   = 2*COORD_BITS + 2;
    localparam int Q   = COORD_BITS + FRAC_BITS;
    localparam int OUT = COORD_BITS + FRAC_BITS;

    // Chain of cells: index 0 is the setup output, index Q the last cell.
    ctrl_t               ch_ctrl [0:Q];
    logic [M-1:0]        ch_rx   [0:Q];
    logic [M-1:0]        ch_ry   [0:Q];
    logic [Q-1:0]        ch_lx   [0:Q];
    logic [Q-1:0]        ch_ly   [0:Q];
    logic [Q-1:0]        ch_qx   [0:Q];
    logic [Q-1:0]        ch_qy   [0:Q];
    logic [M-1:0]        ch_d    [0:Q];
    logic signed [C-1:0] ch_bx   [0:Q];
    logic signed [C-1:0] ch_by   [0:Q];

    logic                        out_valid_reg;
    logic                        hit_reg;
    logic signed [OUT-1:0]       cx_reg, cy_reg;
    logic                        en;
    logic signed [OUT-1:0]       fx_base, fy_base;
    logic signed [OUT-1:0]       cx_next, cy_next;

    // Advance unless a result is stuck in the output register.
    assign en             = !out_valid_reg || result.ready;
    assign seg_pair.ready = en;

    si_setup #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seg_pair.valid),
        .a_start_x (seg_pair.a_start_x),
        .a_start_y (seg_pair.a_start_y),
        .a_end_x   (seg_pair.a_end_x),
        .a_end_y   (seg_pair.a_end_y),
        .b_start_x (seg_pair.b_start_x),
        .b_start_y (seg_pair.b_start_y),
        .b_end_x   (seg_pair.b_end_x),
        .b_end_y   (seg_pair.b_end_y),
        .ctrl      (ch_ctrl[0]),
        .rem_x     (ch_rx[0]),
        .rem_y     (ch_ry[0]),
        .low_x     (ch_lx[0]),
        .low_y     (ch_ly[0]),
        .dvs       (ch_d[0]),
        .base_x    (ch_bx[0]),
        .base_y    (ch_by[0])
    );

    assign ch_qx[0] = '0;
    assign ch_qy[0] = '0;

    // One quotient bit per cell, MSB first.
    for (genvar k = 0; k < Q; k++)
    begin : g_cell
        si_div_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .ctrl_in    (ch_ctrl[k]),
            .rem_x_in   (ch_rx[k]),
            .rem_y_in   (ch_ry[k]),
            .low_x_in   (ch_lx[k]),
            .low_y_in   (ch_ly[k]),
            .q_x_in     (ch_qx[k]),
            .q_y_in     (ch_qy[k]),
            .dvs_in     (ch_d[k]),
            .base_x_in  (ch_bx[k]),
            .base_y_in  (ch_by[k]),
            .ctrl_out   (ch_ctrl[k+1]),
            .rem_x_out  (ch_rx[k+1]),
            .rem_y_out  (ch_ry[k+1]),
            .low_x_out  (ch_lx[k+1]),
            .low_y_out  (ch_ly[k+1]),
            .q_x_out    (ch_qx[k+1]),
            .q_y_out    (ch_qy[k+1]),
            .dvs_out    (ch_d[k+1]),
            .base_x_out (ch_bx[k+1]),
            .base_y_out (ch_by[k+1])
        );
    end

    // Final point: base scaled to fixed point, plus or minus the quotient,
    // wrapping to the output width. Zero without a hit.
    always_comb
    begin
        fx_base = OUT'(ch_bx[Q]) <<< FRAC_BITS;
        fy_base = OUT'(ch_by[Q]) <<< FRAC_BITS;
        cx_next = ch_ctrl[Q].neg_x ? fx_base - OUT'(ch_qx[Q]) : fx_base + OUT'(ch_qx[Q]);
        cy_next = ch_ctrl[Q].neg_y ? fy_base - OUT'(ch_qy[Q]) : fy_base + OUT'(ch_qy[Q]);
        if (!ch_ctrl[Q].hit)
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ch_ctrl[Q].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= ch_ctrl[Q].hit;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.hit     = hit_reg;
    assign result.cross_x = cx_reg;
    assign result.cross_y = cy_reg;

endmodule

// ===== src/si_checker.sv =====
// ----------------------------------------------------------------------------
// si_checker
// Port-level checks for segment_intersection, attached by bind.
// ----------------------------------------------------------------------------
module si_checker #(
    parameter int OUT_BITS = 24
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                hit,
    input logic [OUT_BITS-1:0] cross_x,
    input logic [OUT_BITS-1:0] cross_y
);
    // a missed result keeps valid up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // no hit means a zero point
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("nonzero point without hit");

    // an empty output register never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a result being taken never holds off input: ready follows the sink
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while result taken");

endmodule

bind segment_intersection si_checker #(
    .OUT_BITS (COORD_BITS + FRAC_BITS)
) u_si_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (seg_pair.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .hit       (result.hit),
    .cross_x   (result.cross_x),
    .cross_y   (result.cross_y)
);
